FILE: rtl/core/priority_run_to_completion_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// Scheduler core assertion macros
// Shared concurrent assertion forms for the scheduler core modules.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_RUN_TO_COMPLETION_SCHEDULER_CORE_MACROS_SVH
`define PRIORITY_RUN_TO_COMPLETION_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RPSCH_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler core assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RPSCH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler core assertion failed");

`endif

FILE: rtl/core/rpsch_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler core package
// Queue sizing, action codes and the types shared by the scheduler modules.
// ----------------------------------------------------------------------------
package rpsch_pkg;

  localparam int QDEPTH   = 16;
  localparam int IDX_W    = $clog2(QDEPTH);
  localparam int CNT_W    = $clog2(QDEPTH + 1);
  localparam int QCOUNT_W = 5;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] runtime;
    logic [7:0]  prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t entry;
  } qcmd_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
    entry_t           head;
  } qstat_t;

endpackage

FILE: rtl/core/priority_run_to_completion_scheduler_core.sv
// ----------------------------------------------------------------------------
// Priority run-to-completion scheduler core
// Non-preemptive scheduler with a sorted ready queue of QDEPTH jobs.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. action 0 enqueues a job
// (lower priority value first, equal priorities in arrival order, dropped
// with overflow when the queue is full); action 1 is one tick, which counts
// down the running job, reports it on done_id when it finishes and then
// dispatches the queue head if the CPU is idle. Every word produces exactly
// one result word, shown for a single cycle with result_valid high; the
// receiver cannot stall it, so it must take the word in that cycle. A tick
// that dispatches nothing and a dropped enqueue are answered without the
// queue engine; an enqueue and a dispatching tick wait for the queue engine,
// which walks the memory one entry at a time to find the insertion point and
// move the entries behind it, or to close the gap after a pop. queue_count
// gives the number of waiting jobs.
// ----------------------------------------------------------------------------
`include "priority_run_to_completion_scheduler_core_macros.svh"

module priority_run_to_completion_scheduler_core
  import rpsch_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                action,
  input  logic [15:0]         new_id,
  input  logic [15:0]         new_runtime,
  input  logic [7:0]          new_priority,
  output logic                busy,
  output logic                result_valid,
  output logic                done_valid,
  output logic [15:0]         done_id,
  output logic                running_valid,
  output logic [15:0]         running_id,
  output logic [QCOUNT_W-1:0] queue_count,
  output logic                overflow
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]  state;
  logic        act;
  entry_t      in_entry;
  logic        cpu_busy;
  logic [15:0] cur_id;
  logic [15:0] rem_time;
  logic        done_r;
  logic [15:0] done_id_r;
  logic        ovf_r;

  logic        accept;
  logic        full;
  logic        tick_done;
  logic        busy_after;
  qcmd_t       qcmd;
  qstat_t      qstat;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign full       = (qstat.count == CNT_W'(QDEPTH));
  assign tick_done  = cpu_busy && (rem_time <= 16'd1);
  assign busy_after = cpu_busy && !tick_done;

  assign qcmd.ins   = (state == ST_EXEC) && (act == ACT_ENQUEUE) && !full;
  assign qcmd.pop   = (state == ST_EXEC) && (act == ACT_TICK) && !busy_after &&
                      (qstat.count != '0);
  assign qcmd.entry = in_entry;

  rpsch_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (qcmd),
    .stat (qstat)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= action;
      in_entry <= '{id: new_id, runtime: new_runtime, prio: new_priority};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cpu_busy     <= 1'b0;
      cur_id       <= '0;
      rem_time     <= '0;
      result_valid <= 1'b0;
      done_r       <= 1'b0;
      done_id_r    <= '0;
      ovf_r        <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (act == ACT_ENQUEUE) begin
            done_r    <= 1'b0;
            done_id_r <= '0;
            ovf_r     <= full;
            if (full) begin
              result_valid <= 1'b1;
              state        <= ST_IDLE;
            end else begin
              state <= ST_WAIT;
            end
          end else begin
            ovf_r     <= 1'b0;
            done_r    <= tick_done;
            done_id_r <= tick_done ? cur_id : 16'd0;
            if (tick_done) begin
              cpu_busy <= 1'b0;
              rem_time <= '0;
            end else if (cpu_busy) begin
              rem_time <= rem_time - 16'd1;
            end
            if (qcmd.pop) begin
              state <= ST_WAIT;
            end else begin
              result_valid <= 1'b1;
              state        <= ST_IDLE;
            end
          end
        end
        ST_WAIT: begin
          if (qstat.done) begin
            // A finished pop hands the old head to the CPU.
            if (act == ACT_TICK) begin
              cpu_busy <= 1'b1;
              cur_id   <= qstat.head.id;
              rem_time <= qstat.head.runtime;
            end
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign done_valid    = done_r;
  assign done_id       = done_id_r;
  assign overflow      = ovf_r;
  assign running_valid = cpu_busy;
  assign running_id    = cpu_busy ? cur_id : 16'd0;
  assign queue_count   = QCOUNT_W'(qstat.count);

  `RPSCH_ASSERT_NOW(a_result_idle, clk, rst, result_valid, state == ST_IDLE)
  `RPSCH_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == ST_EXEC)
  `RPSCH_ASSERT_NEXT(a_wait_result, clk, rst, state == ST_WAIT && qstat.done, result_valid)
  `RPSCH_ASSERT_NOW(a_ovf_no_done, clk, rst, ovf_r, !done_r)

endmodule

FILE: rtl/core/rpsch_ram.sv
// ----------------------------------------------------------------------------
// Ready queue memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rpsch_ram
  import rpsch_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [QDEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/rpsch_queue.sv
// ----------------------------------------------------------------------------
// Sorted ready queue engine
// Walks the memory one entry at a time to insert a job in priority order
// or to pop the head and close the gap.
// ----------------------------------------------------------------------------
`include "priority_run_to_completion_scheduler_core_macros.svh"

module rpsch_queue
  import rpsch_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  qcmd_t  cmd,
  output qstat_t stat
);

  localparam logic [3:0] Q_IDLE     = 4'd0;
  localparam logic [3:0] Q_SCAN_RD  = 4'd1;
  localparam logic [3:0] Q_SCAN_CMP = 4'd2;
  localparam logic [3:0] Q_SHIFT_RD = 4'd3;
  localparam logic [3:0] Q_SHIFT_WR = 4'd4;
  localparam logic [3:0] Q_PUT      = 4'd5;
  localparam logic [3:0] Q_POP_RD   = 4'd6;
  localparam logic [3:0] Q_POP_HEAD = 4'd7;
  localparam logic [3:0] Q_PULL_RD  = 4'd8;
  localparam logic [3:0] Q_PULL_WR  = 4'd9;

  logic [3:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] km1;
  logic [CNT_W-1:0] kp1;
  logic             done;
  entry_t           new_entry;
  entry_t           head;

  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] raddr;
  entry_t           rdata;

  assign km1 = k - CNT_W'(1);
  assign kp1 = k + CNT_W'(1);

  rpsch_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = k[IDX_W-1:0];
    wdata = rdata;
    raddr = pos[IDX_W-1:0];
    unique case (state)
      Q_SCAN_RD:  raddr = pos[IDX_W-1:0];
      Q_SHIFT_RD: raddr = km1[IDX_W-1:0];
      Q_SHIFT_WR: begin
        we    = 1'b1;
        waddr = k[IDX_W-1:0];
      end
      Q_PUT: begin
        we    = 1'b1;
        waddr = pos[IDX_W-1:0];
        wdata = new_entry;
      end
      Q_POP_RD:   raddr = '0;
      Q_PULL_RD:  raddr = k[IDX_W-1:0];
      Q_PULL_WR: begin
        we    = 1'b1;
        waddr = km1[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  // New jobs go behind every queued job of equal or smaller priority value.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      count <= '0;
      done  <= 1'b0;
      pos   <= '0;
      k     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        Q_IDLE: begin
          if (cmd.ins) begin
            pos   <= '0;
            state <= Q_SCAN_RD;
          end else if (cmd.pop) begin
            state <= Q_POP_RD;
          end
        end
        Q_SCAN_RD: begin
          if (pos == count) begin
            k     <= count;
            state <= Q_SHIFT_RD;
          end else begin
            state <= Q_SCAN_CMP;
          end
        end
        Q_SCAN_CMP: begin
          if (rdata.prio <= new_entry.prio) begin
            pos   <= pos + CNT_W'(1);
            state <= Q_SCAN_RD;
          end else begin
            k     <= count;
            state <= Q_SHIFT_RD;
          end
        end
        Q_SHIFT_RD: begin
          if (k == pos) begin
            state <= Q_PUT;
          end else begin
            state <= Q_SHIFT_WR;
          end
        end
        Q_SHIFT_WR: begin
          k     <= km1;
          state <= Q_SHIFT_RD;
        end
        Q_PUT: begin
          count <= count + CNT_W'(1);
          done  <= 1'b1;
          state <= Q_IDLE;
        end
        Q_POP_RD: begin
          k     <= CNT_W'(1);
          state <= Q_POP_HEAD;
        end
        Q_POP_HEAD: state <= Q_PULL_RD;
        Q_PULL_RD: begin
          if (k == count) begin
            count <= count - CNT_W'(1);
            done  <= 1'b1;
            state <= Q_IDLE;
          end else begin
            state <= Q_PULL_WR;
          end
        end
        Q_PULL_WR: begin
          k     <= kp1;
          state <= Q_PULL_RD;
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == Q_IDLE && cmd.ins) begin
      new_entry <= cmd.entry;
    end
    if (state == Q_POP_HEAD) begin
      head <= rdata;
    end
  end

  assign stat.done  = done;
  assign stat.count = count;
  assign stat.head  = head;

  `RPSCH_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(QDEPTH))
  `RPSCH_ASSERT_NOW(a_ins_has_room, clk, rst, cmd.ins, count < CNT_W'(QDEPTH))
  `RPSCH_ASSERT_NOW(a_pop_has_job, clk, rst, cmd.pop, count != '0)
  `RPSCH_ASSERT_NEXT(a_done_idle, clk, rst, state == Q_PUT, done && state == Q_IDLE)

endmodule
